// ----- sv/dpmw_pkg.sv -----
// Package for the dense Prim spanning tree block: payload structs, request codes,
// defaults and the command and status groups between controller and datapath.
// No dependencies.
package dpmw_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int TOTAL_BITS       = 20;
  localparam int SIZE_BITS        = 5;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_SUBSET = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  from_vertex;
    logic [3:0]  to_vertex;
    logic [15:0] weight;
    logic [3:0]  slot;
    logic [3:0]  member;
  } dpmw_in_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total_weight;
    logic                  connected;
  } dpmw_out_t;

  typedef struct packed {
    logic load_w;
    logic load_s;
    logic init_run;
    logic fetch_row;
    logic latch_row;
    logic scan_start;
    logic scan_issue;
    logic commit;
    logic emit;
    logic emit_ok;
  } dpmw_cmd_t;

  typedef struct packed {
    logic n_one;
    logic scan_last;
    logic pipe_busy;
    logic found;
    logic last_add;
  } dpmw_sts_t;

endpackage

// ----- sv/dense_prim_mst_weight.sv -----
// Channel   Signals                              Moves
// in        in_valid_i / in_stall_o / in_data_i  one load or start item
// out       out_valid_o / out_stall_i / out_data_o  one result item per start
// cfg       cfg_wr_en_i / cfg_wr_data_i          subset size write, taken at once
// A start with n vertices runs up to n - 1 relaxation passes, each made of the row fetch,
// the row latch, n - 1 issues into the three-stage pipeline, the pipeline drain and a check
// that commits the best candidate or, if none was found, ends the start; the emit follows.
// Reset clears the control state; memory contents are kept undefined until written.
// A result held by out_stall_i does not block loads, but a start finishes only once
// the output register is free.
module dense_prim_mst_weight #(
  parameter int MAX_VERTICES = dpmw_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = dpmw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [dpmw_pkg::SIZE_BITS-1:0] cfg_wr_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dpmw_pkg::dpmw_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dpmw_pkg::dpmw_out_t            out_data_o
);
  import dpmw_pkg::*;

  dpmw_cmd_t cmd;
  dpmw_sts_t sts;

  dpmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpmw_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_data_i     (in_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- sv/dpmw_dp.sv -----
// Datapath of the spanning tree block: weight matrix, subset list and best link
// memories, the three-stage relaxation pipeline, minimum tracking and the result register.
// Depends on dpmw_pkg.
module dpmw_dp #(
  parameter int MAX_VERTICES = dpmw_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = dpmw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [dpmw_pkg::SIZE_BITS-1:0]    cfg_wr_data_i,
  input  dpmw_pkg::dpmw_in_t                in_data_i,
  input  dpmw_pkg::dpmw_cmd_t               cmd_i,
  output dpmw_pkg::dpmw_sts_t               sts_o,
  output dpmw_pkg::dpmw_out_t               out_data_o
);
  import dpmw_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NB    = VW + 1;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [WEIGHT_BITS-1:0] WMASK = {WEIGHT_BITS{1'b1}};

  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [VW-1:0]          smem [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] bmem [MAX_VERTICES];

  logic [SIZE_BITS-1:0]   size_q;
  logic [NB-1:0]          n_q, n_d;
  logic [MAX_VERTICES-1:0] in_tree_q;
  logic [VW-1:0]          pick_q, row_q, scan_p_q, added_q;
  logic                   init_q;
  logic [TOTAL_BITS-1:0]  total_q;
  logic [WEIGHT_BITS-1:0] low_q;
  logic [VW-1:0]          cand_q;
  logic                   found_q;
  logic                   v1_q, v2_q;
  logic [VW-1:0]          p1_q, p2_q;
  logic [VW-1:0]          s_rd_q;
  logic [WEIGHT_BITS-1:0] w_rd_q, b_rd_q;
  logic [VW-1:0]          s_raddr;
  logic [AW-1:0]          w_waddr, w_raddr;
  logic                   w_in_range, s_in_range;
  logic [WEIGHT_BITS-1:0] nb;
  logic                   relax;
  dpmw_out_t              out_q;

  // Effective vertex count: zero counts as one, anything above the capacity saturates.
  always_comb begin
    if (size_q <= SIZE_BITS'(1)) begin
      n_d = NB'(1);
    end else if (32'(size_q) > MAX_VERTICES) begin
      n_d = NB'(MAX_VERTICES);
    end else begin
      n_d = NB'(size_q);
    end
  end

  assign w_in_range = (32'(in_data_i.from_vertex) < MAX_VERTICES) &&
                      (32'(in_data_i.to_vertex) < MAX_VERTICES);
  assign s_in_range = (32'(in_data_i.slot) < MAX_VERTICES) &&
                      (32'(in_data_i.member) < MAX_VERTICES);
  assign w_waddr = AW'(32'(in_data_i.from_vertex) * MAX_VERTICES + 32'(in_data_i.to_vertex));
  assign w_raddr = AW'(32'(row_q) * MAX_VERTICES + 32'(s_rd_q));
  assign s_raddr = cmd_i.fetch_row ? pick_q : scan_p_q;

  // The first pass takes the edge from the root as it stands; later passes keep the lower.
  always_comb begin
    if (init_q || (w_rd_q < b_rd_q)) begin
      nb = w_rd_q;
    end else begin
      nb = b_rd_q;
    end
  end
  assign relax = v2_q && !in_tree_q[p2_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_w && w_in_range) begin
      wmem[w_waddr] <= WEIGHT_BITS'(in_data_i.weight);
    end
    w_rd_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_s && s_in_range) begin
      smem[VW'(in_data_i.slot)] <= VW'(in_data_i.member);
    end
    s_rd_q <= smem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (relax) begin
      bmem[p2_q] <= nb;
    end
    b_rd_q <= bmem[p1_q];
  end

  always_ff @(posedge clk_i) begin
    p1_q <= scan_p_q;
    p2_q <= p1_q;
    if (cmd_i.latch_row) begin
      row_q <= s_rd_q;
    end
    if (cmd_i.emit) begin
      out_q.total_weight <= cmd_i.emit_ok ? total_q : '0;
      out_q.connected    <= cmd_i.emit_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SIZE_BITS'(1);
      n_q       <= NB'(1);
      in_tree_q <= '0;
      pick_q    <= '0;
      scan_p_q  <= '0;
      added_q   <= '0;
      init_q    <= 1'b0;
      total_q   <= '0;
      low_q     <= WMASK;
      cand_q    <= '0;
      found_q   <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        size_q <= cfg_wr_data_i;
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      if (cmd_i.init_run) begin
        n_q       <= n_d;
        in_tree_q <= MAX_VERTICES'(1);
        pick_q    <= '0;
        added_q   <= '0;
        init_q    <= 1'b1;
        total_q   <= '0;
      end
      if (cmd_i.scan_start) begin
        scan_p_q <= VW'(1);
        low_q    <= WMASK;
        cand_q   <= '0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_issue) begin
        scan_p_q <= scan_p_q + VW'(1);
      end
      // Strictly lower only, so ties stay with the lower position scanned first.
      if (relax && (nb < low_q)) begin
        low_q   <= nb;
        cand_q  <= p2_q;
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        total_q           <= total_q + TOTAL_BITS'(low_q);
        in_tree_q[cand_q] <= 1'b1;
        pick_q            <= cand_q;
        added_q           <= added_q + VW'(1);
        init_q            <= 1'b0;
      end
    end
  end

  assign sts_o.n_one     = (n_d == NB'(1));
  assign sts_o.scan_last = (scan_p_q == VW'(n_q - NB'(1)));
  assign sts_o.pipe_busy = v1_q || v2_q;
  assign sts_o.found     = found_q;
  assign sts_o.last_add  = ((NB'(added_q) + NB'(2)) == n_q);
  assign out_data_o      = out_q;

endmodule

// ----- sv/dpmw_ctrl.sv -----
// Controller of the spanning tree block: request decode, the pass sequencer
// and the output valid register. Depends on dpmw_pkg.
module dpmw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  dpmw_pkg::dpmw_sts_t  sts_i,
  output dpmw_pkg::dpmw_cmd_t  cmd_o
);
  import dpmw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_LATCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ok_q, ok_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire, slot_free;

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ok_d        = ok_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.load_w = in_fire && (req_type_i == REQ_WEIGHT);
    cmd_o.load_s = in_fire && (req_type_i == REQ_SUBSET);
    case (state_q)
      S_IDLE: begin
        if (in_fire && (req_type_i == REQ_START)) begin
          cmd_o.init_run = 1'b1;
          ok_d           = 1'b1;
          state_d        = sts_i.n_one ? S_DONE : S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.fetch_row = 1'b1;
        state_d         = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch_row  = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.found) begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.last_add ? S_DONE : S_ROW;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_ok = ok_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/dpmw_chk.sv -----
// Port-level checker for the spanning tree block, bound to the top level.
// Depends on dpmw_pkg and dense_prim_mst_weight.
module dpmw_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input dpmw_pkg::dpmw_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dpmw_pkg::dpmw_out_t out_data_o
);
  import dpmw_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A disconnected result always carries a zero total.
  a_disc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.connected |-> out_data_o.total_weight == '0)
    else $error("disconnected result with non-zero total");

  // A start item occupies the block on the following cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == REQ_START |=> in_stall_o)
    else $error("block not busy after a start item");

  // A load leaves the block free for the next item on the following cycle.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == REQ_WEIGHT ||
    in_data_i.req_type == REQ_SUBSET) |=> !in_stall_o)
    else $error("block busy after a load item");

  // A new result only appears at the end of a computation.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without a computation");

endmodule

bind dense_prim_mst_weight dpmw_chk u_chk (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for dense_prim_mst_weight, the dense Prim spanning tree block.
// Needs dpmw_pkg and the block itself. Some directed starts are checked against fixed values;
// the rest against a spanning tree worked out from a mirror of weights, subsets and size.
`timescale 1ns / 1ps

module testbench;
  import dpmw_pkg::*;

  localparam int MAX_V = MAX_VERTICES_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [15:0] NO_EDGE = 16'hFFFF;
  localparam int RANDOM_ITEMS = 750;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_PHASE = 4;
  localparam int SEND_IDLE [3] = '{36, 69, 0};
  localparam int RECV_IDLE [3] = '{69, 36, 0};
  localparam logic [SIZE_BITS-1:0] PHASE_SIZES [16] = '{
    5'd2, 5'd5, 5'd3, 5'd1, 5'd2, 5'd7, 5'd0, 5'd4,
    5'd16, 5'd3, 5'd12, 5'd6, 5'd31, 5'd2, 5'd17, 5'd9
  };
  localparam dpmw_out_t NO_FIX = '0;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    dpmw_in_t             item;
    logic [SIZE_BITS-1:0] size_val;
    bit                   fixed_ok;
    dpmw_out_t            fixed;
  } drow_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [SIZE_BITS-1:0] cfg_wr_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  dpmw_in_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  dpmw_out_t            out_data_o;

  // Mirror of the block's stores, with a flag per entry that has been written.
  logic [15:0]          wmat [MAX_V][MAX_V];
  bit                   wmat_set [MAX_V][MAX_V];
  logic [3:0]           slist [MAX_V];
  bit                   slist_set [MAX_V];
  logic [SIZE_BITS-1:0] tree_size = 5'd1;

  dpmw_out_t pending_trees [$];
  int        tree_errors = 0;
  int        items_sent = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_req = 1'b0;
  drow_t     dir_rows [22];

  dense_prim_mst_weight dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic dpmw_in_t mk_weight(input logic [3:0] f, input logic [3:0] t,
                                         input logic [15:0] w);
    dpmw_in_t it;
    it = '0;
    it.req_type = REQ_WEIGHT;
    it.from_vertex = f;
    it.to_vertex = t;
    it.weight = w;
    return it;
  endfunction

  function automatic dpmw_in_t mk_subset(input logic [3:0] s, input logic [3:0] m);
    dpmw_in_t it;
    it = '0;
    it.req_type = REQ_SUBSET;
    it.slot = s;
    it.member = m;
    return it;
  endfunction

  // Start items carry random junk in the unused fields.
  function automatic dpmw_in_t mk_start();
    dpmw_in_t it;
    it = {REQ_START, 32'($urandom)};
    return it;
  endfunction

  // Weights lean towards zero, the no-edge code, the largest real weight and small
  // values, so that ties between candidates come up often.
  function automatic logic [15:0] rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 25) return NO_EDGE;
    if (r < 35) return NO_EDGE - 16'd1;
    if (r < 75) return 16'($urandom_range(1, 15));
    return 16'($urandom);
  endfunction

  function automatic int used_size();
    if (tree_size == 0) return 1;
    if (tree_size > MAX_V) return MAX_V;
    return int'(tree_size);
  endfunction

  function automatic logic [15:0] edge_w(input int pa, input int pb);
    return wmat[slist[pa]][slist[pb]];
  endfunction

  function automatic dpmw_out_t grow_tree();
    int          n;
    int          pick;
    int          sum;
    bit          found;
    logic [15:0] low;
    logic [15:0] w;
    logic [15:0] link [MAX_V];
    bit          joined [MAX_V];
    dpmw_out_t   res;
    n = used_size();
    sum = 0;
    for (int p = 0; p < n; p++) begin
      link[p] = edge_w(0, p);
      joined[p] = 1'b0;
    end
    joined[0] = 1'b1;
    for (int step = 0; step + 1 < n; step++) begin
      low = NO_EDGE;
      found = 1'b0;
      pick = 0;
      // Strict compare keeps the lowest position on a tie and never picks a missing edge.
      for (int p = 1; p < n; p++) begin
        if (!joined[p] && link[p] < low) begin
          low = link[p];
          pick = p;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.total_weight = '0;
        res.connected = 1'b0;
        return res;
      end
      sum += int'(low);
      joined[pick] = 1'b1;
      for (int p = 0; p < n; p++) begin
        w = edge_w(pick, p);
        if (!joined[p] && w < link[p]) link[p] = w;
      end
    end
    res.total_weight = TOTAL_BITS'(sum);
    res.connected = 1'b1;
    return res;
  endfunction

  task automatic report_miss(input string what, input int got, input int want);
    tree_errors++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_tree(input dpmw_out_t got);
    dpmw_out_t want;
    if (pending_trees.size() == 0) begin
      report_miss("result item with nothing pending", int'(got.total_weight), 0);
      return;
    end
    want = pending_trees.pop_front();
    if (got.total_weight !== want.total_weight)
      report_miss("total_weight", int'(got.total_weight), int'(want.total_weight));
    if (got.connected !== want.connected)
      report_miss("connected", int'(got.connected), int'(want.connected));
  endtask

  // Offers one item, waits for it to be taken and updates the mirror in step with the block.
  task automatic send_item(input dpmw_in_t it, input bit fixed_ok, input dpmw_out_t fixed);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    case (it.req_type)
      REQ_WEIGHT: begin
        wmat[it.from_vertex][it.to_vertex] = it.weight;
        wmat_set[it.from_vertex][it.to_vertex] = 1'b1;
      end
      REQ_SUBSET: begin
        slist[it.slot] = it.member;
        slist_set[it.slot] = 1'b1;
      end
      REQ_START: pending_trees.push_back(fixed_ok ? fixed : grow_tree());
      default: ;
    endcase
    if (it.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Stops offering, waits for every pending result and lets the block drain its loads.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_trees.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_BITS-1:0] v);
    settle();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    tree_size = v;
  endtask

  // A start must only read entries that hold written values, so any gap is loaded first.
  task automatic fill_gaps();
    int n;
    n = used_size();
    for (int p = 0; p < n; p++)
      if (!slist_set[p]) send_item(mk_subset(4'(p), 4'($urandom_range(15))), 1'b0, NO_FIX);
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (!wmat_set[slist[a]][slist[b]])
          send_item(mk_weight(slist[a], slist[b], rand_weight()), 1'b0, NO_FIX);
  endtask

  // Result side: checks each accepted item and drives stall, with one long hold-off.
  initial begin
    int  hold_left;
    bit  hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) check_tree(out_data_o);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int rand_base;
    int mode;
    int phase;
    int phase_end;
    int pick;
    int n;
    int a;
    int b;
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];

    dir_rows = '{
      '{ROW_ITEM, mk_subset(4'd0, 4'd15), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd15, 4'd15, 16'd0), 5'd0, 1'b0, NO_FIX},
      // Reset size is one: a lone vertex is a tree of weight zero.
      '{ROW_ITEM, mk_start(), 5'd0, 1'b1, {20'd0, 1'b1}},
      '{ROW_ITEM, {REQ_UNUSED, 32'hFFFF_FFFF}, 5'd0, 1'b0, NO_FIX},
      // A size of zero behaves as one.
      '{ROW_SIZE, '0, 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_start(), 5'd0, 1'b1, {20'd0, 1'b1}},
      '{ROW_ITEM, mk_subset(4'd1, 4'd0), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd15, 4'd0, NO_EDGE), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd0, 4'd15, NO_EDGE), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd0, 4'd0, 16'd0), 5'd0, 1'b0, NO_FIX},
      '{ROW_SIZE, '0, 5'd2, 1'b0, NO_FIX},
      // Only a missing edge leads to the second vertex, so it cannot be reached.
      '{ROW_ITEM, mk_start(), 5'd0, 1'b1, {20'd0, 1'b0}},
      '{ROW_ITEM, mk_weight(4'd15, 4'd0, 16'hFFFE), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_start(), 5'd0, 1'b1, {20'h0FFFE, 1'b1}},
      // The same vertex listed twice counts as two positions.
      '{ROW_ITEM, mk_subset(4'd2, 4'd15), 5'd0, 1'b0, NO_FIX},
      '{ROW_SIZE, '0, 5'd3, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_start(), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd0, 4'd15, 16'd0), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_weight(4'd0, 4'd0, NO_EDGE), 5'd0, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_start(), 5'd0, 1'b0, NO_FIX},
      '{ROW_SIZE, '0, 5'd1, 1'b0, NO_FIX},
      '{ROW_ITEM, mk_start(), 5'd0, 1'b1, {20'd0, 1'b1}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) write_size(dir_rows[i].size_val);
      else send_item(dir_rows[i].item, dir_rows[i].fixed_ok, dir_rows[i].fixed);
    end

    rand_base = items_sent;
    phase = 0;
    while (items_sent < rand_base + RANDOM_ITEMS) begin
      mode = (items_sent - rand_base) * 3 / RANDOM_ITEMS;
      if (mode > 2) mode = 2;
      send_idle_pct = SEND_IDLE[mode];
      recv_idle_pct = RECV_IDLE[mode];
      write_size(PHASE_SIZES[phase % 16]);
      // Results back up behind a long receiver hold while the sender keeps offering items.
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      phase_end = items_sent + $urandom_range(25, 60);
      while (items_sent < phase_end && items_sent < rand_base + RANDOM_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(mk_weight(4'($urandom_range(15)), 4'($urandom_range(15)), rand_weight()),
                    1'b0, NO_FIX);
        end else if (pick < 12) begin
          send_item(mk_subset(4'($urandom_range(15)), 4'($urandom_range(15))), 1'b0, NO_FIX);
        end else if (pick < 16) begin
          send_item({REQ_UNUSED, 32'($urandom)}, 1'b0, NO_FIX);
        end else if (pick < 19) begin
          settle();
        end else begin
          n = used_size();
          repeat ($urandom_range(0, 3)) begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            if ($urandom_range(3) == 0 || !slist_set[a] || !slist_set[b])
              send_item(mk_subset(4'(a), 4'($urandom_range(15))), 1'b0, NO_FIX);
            else
              send_item(mk_weight(slist[a], slist[b], rand_weight()), 1'b0, NO_FIX);
          end
          fill_gaps();
          send_item(mk_start(), 1'b0, NO_FIX);
        end
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tree_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dpmw_pkg.sv
sv/dpmw_dp.sv
sv/dpmw_ctrl.sv
sv/dense_prim_mst_weight.sv
sv/dpmw_chk.sv
tb/testbench.sv
